// ===== design/mcppm_pkg.sv =====
// ----------------------------------------------------------------------------
// Pulse period meter package
// Operation codes, field widths and register map shared by the interfaces
// and the meter.
// ----------------------------------------------------------------------------
package mcppm_pkg;

   typedef enum logic [1:0] {
      OP_TICK         = 2'd0,
      OP_READ         = 2'd1,
      OP_CLEAR_WINDOW = 2'd2,
      OP_CLEAR_SUM    = 2'd3
   } opcode_type;

   localparam int OPCODE_BITS  = 2;
   localparam int PIN_BITS     = 3;
   localparam int CHANNEL_BITS = 2;
   localparam int MASK_BITS    = 3;
   localparam int FIELD_BITS   = 16;
   localparam int SUM_BITS     = 32;
   localparam int DIVIDER_BITS = 8;

   // Configuration space: one 32-bit register per word.
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [0:0] CSR_TICKS_PER_MS = 1'b0;  // word index of the divider register

   localparam logic [DIVIDER_BITS-1:0] TICKS_PER_MS_RESET = 8'd10;
   localparam logic [FIELD_BITS-1:0]   COUNT_ONES         = 16'hffff;
   localparam logic [SUM_BITS-1:0]     SUM_ONES           = 32'hffff_ffff;

endpackage

// ===== design/mcppm_if.sv =====
// ----------------------------------------------------------------------------
// Pulse period meter channels
// Request channel (operation beats) and response channel (result beats).
// ----------------------------------------------------------------------------
interface mcppm_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [mcppm_pkg::OPCODE_BITS-1:0]     opcode;
   logic [mcppm_pkg::PIN_BITS-1:0]        pin_levels;
   logic [mcppm_pkg::CHANNEL_BITS-1:0]    channel;

   modport source (output valid, opcode, pin_levels, channel, input ready);
   modport sink   (input valid, opcode, pin_levels, channel, output ready);
endinterface

interface mcppm_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  millisecond_strobe;
   logic [mcppm_pkg::MASK_BITS-1:0]       capture_mask;
   logic [mcppm_pkg::FIELD_BITS-1:0]      period_zero;
   logic [mcppm_pkg::FIELD_BITS-1:0]      period_one;
   logic [mcppm_pkg::FIELD_BITS-1:0]      period_two;
   logic [mcppm_pkg::FIELD_BITS-1:0]      stat_count;
   logic [mcppm_pkg::SUM_BITS-1:0]        stat_sum;
   logic [mcppm_pkg::FIELD_BITS-1:0]      stat_min;
   logic [mcppm_pkg::FIELD_BITS-1:0]      stat_max;
   logic [mcppm_pkg::FIELD_BITS-1:0]      stat_last;

   modport source (output valid, millisecond_strobe, capture_mask, period_zero, period_one,
                   period_two, stat_count, stat_sum, stat_min, stat_max, stat_last,
                   input ready);
   modport sink   (input valid, millisecond_strobe, capture_mask, period_zero, period_one,
                   period_two, stat_count, stat_sum, stat_min, stat_max, stat_last,
                   output ready);
endinterface

// ===== design/multi_channel_pulse_period_meter.sv =====
// ----------------------------------------------------------------------------
// Multi-channel pulse period meter
// Falling-edge detection, period capture and window statistics per channel.
// ----------------------------------------------------------------------------
// Each request beat is either a tick (pin samples for all channels) or a
// read / clear of one channel's statistics, and yields exactly one response
// beat. A beat is captured into an input register and resolved, once the
// response register is free, by one pass of per-channel compare and increment
// logic into the response register, so the meter sustains one beat per clock
// while the response side keeps ready high. Read and clear responses
// report the statistics as they stood before the operation. The millisecond
// divider is written through the APB port at word 0 and should only be changed
// while no beats are in flight.
module multi_channel_pulse_period_meter #(
   parameter int CHANNELS    = 3,
   parameter int PERIOD_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   mcppm_req_if.sink                             req_bus,
   mcppm_rsp_if.source                           rsp_bus,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [mcppm_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [mcppm_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [mcppm_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                  pready
);

   localparam int SLOTS = (CHANNELS > mcppm_pkg::MASK_BITS) ? CHANNELS : mcppm_pkg::MASK_BITS;
   localparam int FB    = mcppm_pkg::FIELD_BITS;
   localparam int PINX  = CHANNELS + mcppm_pkg::PIN_BITS;
   localparam logic [PERIOD_BITS-1:0] PERIOD_ONES = {PERIOD_BITS{1'b1}};

   // Configuration
   logic [mcppm_pkg::DIVIDER_BITS-1:0] tpm_ff, tpm_in;
   logic                                csr_write;

   // Input stage
   logic                                s_valid_ff, s_valid_in;
   logic [mcppm_pkg::OPCODE_BITS-1:0]   s_opcode_ff;
   logic [mcppm_pkg::PIN_BITS-1:0]      s_pins_ff;
   logic [mcppm_pkg::CHANNEL_BITS-1:0]  s_channel_ff;
   logic                                advance;

   // Per-channel state
   logic                      prev_ff [CHANNELS];
   logic                      prev_in [CHANNELS];
   logic                      counting_ff [CHANNELS];
   logic                      counting_in [CHANNELS];
   logic [PERIOD_BITS-1:0]    period_ff [CHANNELS];
   logic [PERIOD_BITS-1:0]    period_in [CHANNELS];
   logic [PERIOD_BITS-1:0]    last_ff [CHANNELS];
   logic [PERIOD_BITS-1:0]    last_in [CHANNELS];
   logic [FB-1:0]             count_ff [CHANNELS];
   logic [FB-1:0]             count_in [CHANNELS];
   logic [mcppm_pkg::SUM_BITS-1:0] sum_ff [CHANNELS];
   logic [mcppm_pkg::SUM_BITS-1:0] sum_in [CHANNELS];
   logic [PERIOD_BITS-1:0]    min_ff [CHANNELS];
   logic [PERIOD_BITS-1:0]    min_in [CHANNELS];
   logic [PERIOD_BITS-1:0]    max_ff [CHANNELS];
   logic [PERIOD_BITS-1:0]    max_in [CHANNELS];
   logic [mcppm_pkg::DIVIDER_BITS-1:0] div_ff, div_in;

   // Response register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                strobe_ff, strobe_in;
   logic [mcppm_pkg::MASK_BITS-1:0]     mask_ff, mask_in;
   logic [FB-1:0]                       per0_ff, per0_in;
   logic [FB-1:0]                       per1_ff, per1_in;
   logic [FB-1:0]                       per2_ff, per2_in;
   logic [FB-1:0]                       st_count_ff, st_count_in;
   logic [mcppm_pkg::SUM_BITS-1:0]      st_sum_ff, st_sum_in;
   logic [FB-1:0]                       st_min_ff, st_min_in;
   logic [FB-1:0]                       st_max_ff, st_max_in;
   logic [FB-1:0]                       st_last_ff, st_last_in;

   // ---------------------------------------------------------------- APB
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_comb begin
      tpm_in = tpm_ff;
      if (csr_write && (paddr[mcppm_pkg::CSR_ADDR_BITS-1 -: 1] == mcppm_pkg::CSR_TICKS_PER_MS)) begin
         tpm_in = pwdata[mcppm_pkg::DIVIDER_BITS-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[mcppm_pkg::CSR_ADDR_BITS-1 -: 1] == mcppm_pkg::CSR_TICKS_PER_MS) begin
         prdata = {{(mcppm_pkg::CSR_DATA_BITS-mcppm_pkg::DIVIDER_BITS){1'b0}}, tpm_ff};
      end
   end

   // ---------------------------------------------------------------- handshake
   assign advance       = s_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s_valid_ff || advance;

   always_comb begin
      s_valid_in = s_valid_ff;
      if (req_bus.ready) begin
         s_valid_in = req_bus.valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin
      logic [PINX-1:0]           pins_wide;
      logic [PERIOD_BITS-1:0]    pc;
      logic [PERIOD_BITS+FB-1:0] wide;
      logic [mcppm_pkg::DIVIDER_BITS-1:0] div_inc;
      logic [FB-1:0]             cap_period [SLOTS];
      logic [SLOTS-1:0]          cap_mask;
      logic                      now;

      pins_wide = {{CHANNELS{1'b0}}, s_pins_ff};
      div_inc   = div_ff + 1'b1;
      pc        = '0;
      wide      = '0;
      now       = 1'b0;
      cap_mask  = '0;
      for (int k = 0; k < SLOTS; k++) begin
         cap_period[k] = '0;
      end

      div_in    = div_ff;
      strobe_in = 1'b0;
      st_count_in = '0;
      st_sum_in   = '0;
      st_min_in   = '0;
      st_max_in   = '0;
      st_last_in  = '0;

      for (int c = 0; c < CHANNELS; c++) begin
         prev_in[c]     = prev_ff[c];
         counting_in[c] = counting_ff[c];
         period_in[c]   = period_ff[c];
         last_in[c]     = last_ff[c];
         count_in[c]    = count_ff[c];
         sum_in[c]      = sum_ff[c];
         min_in[c]      = min_ff[c];
         max_in[c]      = max_ff[c];
      end

      if (advance) begin
         if (s_opcode_ff == mcppm_pkg::OP_TICK) begin
            for (int c = 0; c < CHANNELS; c++) begin
               now = pins_wide[c];
               pc  = period_ff[c];
               if (counting_ff[c] && (pc != PERIOD_ONES)) begin
                  pc = pc + 1'b1;
               end
               period_in[c] = pc;
               if (!now && prev_ff[c]) begin
                  if (count_ff[c] != mcppm_pkg::COUNT_ONES) begin
                     count_in[c] = count_ff[c] + 1'b1;
                  end
                  if (sum_ff[c] != mcppm_pkg::SUM_ONES) begin
                     sum_in[c] = sum_ff[c] + 1'b1;
                  end
                  if (counting_ff[c]) begin
                     last_in[c] = pc;
                     if (pc < min_ff[c]) begin
                        min_in[c] = pc;
                     end
                     if ((pc > max_ff[c]) && (pc != PERIOD_ONES)) begin
                        max_in[c] = pc;
                     end
                     cap_mask[c]   = 1'b1;
                     wide          = {{FB{1'b0}}, pc};
                     cap_period[c] = wide[FB-1:0];
                  end
                  period_in[c]   = '0;
                  counting_in[c] = 1'b1;
               end
               prev_in[c] = now;
            end
            if (div_inc == tpm_ff) begin
               div_in    = '0;
               strobe_in = 1'b1;
            end else begin
               div_in = div_inc;
            end
         end else begin
            // Read and clear beats report the selected channel before any clearing.
            for (int c = 0; c < CHANNELS; c++) begin
               if (c == int'(s_channel_ff)) begin
                  st_count_in = count_ff[c];
                  st_sum_in   = sum_ff[c];
                  wide        = {{FB{1'b0}}, min_ff[c]};
                  st_min_in   = wide[FB-1:0];
                  wide        = {{FB{1'b0}}, max_ff[c]};
                  st_max_in   = wide[FB-1:0];
                  wide        = {{FB{1'b0}}, last_ff[c]};
                  st_last_in  = wide[FB-1:0];
                  if (s_opcode_ff == mcppm_pkg::OP_CLEAR_WINDOW) begin
                     count_in[c] = '0;
                     min_in[c]   = PERIOD_ONES;
                     max_in[c]   = '0;
                  end else if (s_opcode_ff == mcppm_pkg::OP_CLEAR_SUM) begin
                     sum_in[c] = '0;
                  end
               end
            end
         end
      end

      mask_in = cap_mask[mcppm_pkg::MASK_BITS-1:0];
      per0_in = cap_period[0];
      per1_in = cap_period[1];
      per2_in = cap_period[2];
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tpm_ff       <= mcppm_pkg::TICKS_PER_MS_RESET;
         s_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         div_ff       <= '0;
         for (int c = 0; c < CHANNELS; c++) begin
            prev_ff[c]     <= 1'b0;
            counting_ff[c] <= 1'b0;
            period_ff[c]   <= '0;
            last_ff[c]     <= '0;
            count_ff[c]    <= '0;
            sum_ff[c]      <= '0;
            min_ff[c]      <= PERIOD_ONES;
            max_ff[c]      <= '0;
         end
      end else begin
         tpm_ff       <= tpm_in;
         s_valid_ff   <= s_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         div_ff       <= div_in;
         for (int c = 0; c < CHANNELS; c++) begin
            prev_ff[c]     <= prev_in[c];
            counting_ff[c] <= counting_in[c];
            period_ff[c]   <= period_in[c];
            last_ff[c]     <= last_in[c];
            count_ff[c]    <= count_in[c];
            sum_ff[c]      <= sum_in[c];
            min_ff[c]      <= min_in[c];
            max_ff[c]      <= max_in[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         s_opcode_ff  <= req_bus.opcode;
         s_pins_ff    <= req_bus.pin_levels;
         s_channel_ff <= req_bus.channel;
      end
      if (advance) begin
         strobe_ff   <= strobe_in;
         mask_ff     <= mask_in;
         per0_ff     <= per0_in;
         per1_ff     <= per1_in;
         per2_ff     <= per2_in;
         st_count_ff <= st_count_in;
         st_sum_ff   <= st_sum_in;
         st_min_ff   <= st_min_in;
         st_max_ff   <= st_max_in;
         st_last_ff  <= st_last_in;
      end
   end

   assign rsp_bus.valid              = rsp_valid_ff;
   assign rsp_bus.millisecond_strobe = strobe_ff;
   assign rsp_bus.capture_mask       = mask_ff;
   assign rsp_bus.period_zero        = per0_ff;
   assign rsp_bus.period_one         = per1_ff;
   assign rsp_bus.period_two         = per2_ff;
   assign rsp_bus.stat_count         = st_count_ff;
   assign rsp_bus.stat_sum           = st_sum_ff;
   assign rsp_bus.stat_min           = st_min_ff;
   assign rsp_bus.stat_max           = st_max_ff;
   assign rsp_bus.stat_last          = st_last_ff;

endmodule

// ===== bench/multi_channel_pulse_period_meter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse period meter testbench
// Drives tick, read and clear beats into the meter with random gaps and
// response stalls. A predictor of the per-channel counters computes every
// response beat, which is checked field by field. The divider register is
// rewritten between phases over the APB port and read back.
// ----------------------------------------------------------------------------
module multi_channel_pulse_period_meter_tb;

   localparam int CHANNEL_COUNT = 3;
   localparam int CYCLE_LIMIT   = 100_000;
   localparam logic [mcppm_pkg::FIELD_BITS-1:0]    PERIOD_ONES  = '1;
   localparam logic [mcppm_pkg::CSR_ADDR_BITS-1:0] DIVIDER_ADDR =
      {mcppm_pkg::CSR_TICKS_PER_MS, 2'b00};

   typedef logic [mcppm_pkg::PIN_BITS-1:0]     pin_set_type;
   typedef logic [mcppm_pkg::CHANNEL_BITS-1:0] channel_sel_type;
   typedef logic [mcppm_pkg::DIVIDER_BITS-1:0] divider_type;

   typedef struct packed {
      mcppm_pkg::opcode_type    opcode;
      pin_set_type              pins;
      channel_sel_type          channel;
   } meter_op_type;

   typedef struct packed {
      logic                                strobe;
      logic [mcppm_pkg::MASK_BITS-1:0]     mask;
      logic [mcppm_pkg::FIELD_BITS-1:0]    period_zero;
      logic [mcppm_pkg::FIELD_BITS-1:0]    period_one;
      logic [mcppm_pkg::FIELD_BITS-1:0]    period_two;
      logic [mcppm_pkg::FIELD_BITS-1:0]    edges;
      logic [mcppm_pkg::SUM_BITS-1:0]      total;
      logic [mcppm_pkg::FIELD_BITS-1:0]    shortest;
      logic [mcppm_pkg::FIELD_BITS-1:0]    longest;
      logic [mcppm_pkg::FIELD_BITS-1:0]    latest;
   } meter_reading_type;

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [mcppm_pkg::CSR_ADDR_BITS-1:0] paddr;
   logic [mcppm_pkg::CSR_DATA_BITS-1:0] pwdata;
   logic [mcppm_pkg::CSR_DATA_BITS-1:0] prdata;
   logic pready;

   mcppm_req_if req_bus ();
   mcppm_rsp_if rsp_bus ();

   multi_channel_pulse_period_meter uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Predictor state, one entry per channel.
   logic [CHANNEL_COUNT-1:0] prev_level;
   logic [CHANNEL_COUNT-1:0] counting;
   logic [mcppm_pkg::FIELD_BITS-1:0]    period_cnt   [CHANNEL_COUNT];
   logic [mcppm_pkg::FIELD_BITS-1:0]    last_capture [CHANNEL_COUNT];
   logic [mcppm_pkg::FIELD_BITS-1:0]    window_edges [CHANNEL_COUNT];
   logic [mcppm_pkg::SUM_BITS-1:0]      total_edges  [CHANNEL_COUNT];
   logic [mcppm_pkg::FIELD_BITS-1:0]    min_capture  [CHANNEL_COUNT];
   logic [mcppm_pkg::FIELD_BITS-1:0]    max_capture  [CHANNEL_COUNT];
   divider_type  divider;
   divider_type  divider_limit;

   meter_op_type      op_backlog [$];
   meter_reading_type predicted_readings [$];
   meter_op_type      next_op;
   meter_op_type      seen_op;
   meter_reading_type want;

   int  queued_ops;
   int  accepted_ops = 0;
   int  checked_readings = 0;
   int  mismatches = 0;
   int  cycle_count = 0;
   int  send_hold;
   int  stall_left;
   bit  req_taken;
   bit  no_idling;

   // Square-wave generators that give the random ticks realistic pulse trains.
   bit  wave_level [CHANNEL_COUNT];
   int  wave_left  [CHANNEL_COUNT];

   function automatic meter_reading_type advance_meter(meter_op_type op);
      meter_reading_type r;
      logic [mcppm_pkg::FIELD_BITS-1:0] captured [CHANNEL_COUNT];
      logic [mcppm_pkg::FIELD_BITS-1:0] p;
      int sel;
      r = '0;
      foreach (captured[c]) captured[c] = '0;
      if (op.opcode == mcppm_pkg::OP_TICK) begin
         for (int c = 0; c < CHANNEL_COUNT; c++) begin
            if (counting[c] && period_cnt[c] != PERIOD_ONES)
               period_cnt[c] = period_cnt[c] + 1'b1;
            if (!op.pins[c] && prev_level[c]) begin
               if (window_edges[c] != mcppm_pkg::COUNT_ONES)
                  window_edges[c] = window_edges[c] + 1'b1;
               if (total_edges[c] != mcppm_pkg::SUM_ONES)
                  total_edges[c] = total_edges[c] + 1'b1;
               // The first edge only arms the channel; later edges close a period.
               if (counting[c]) begin
                  p = period_cnt[c];
                  last_capture[c] = p;
                  if (p < min_capture[c])
                     min_capture[c] = p;
                  if (p > max_capture[c] && p != PERIOD_ONES)
                     max_capture[c] = p;
                  r.mask[c] = 1'b1;
                  captured[c] = p;
               end
               period_cnt[c] = '0;
               counting[c] = 1'b1;
            end
            prev_level[c] = op.pins[c];
         end
         r.period_zero = captured[0];
         r.period_one  = captured[1];
         r.period_two  = captured[2];
         divider = divider + 1'b1;
         if (divider == divider_limit) begin
            divider = '0;
            r.strobe = 1'b1;
         end
      end else if (op.channel < CHANNEL_COUNT) begin
         sel = op.channel;
         r.edges    = window_edges[sel];
         r.total    = total_edges[sel];
         r.shortest = min_capture[sel];
         r.longest  = max_capture[sel];
         r.latest   = last_capture[sel];
         if (op.opcode == mcppm_pkg::OP_CLEAR_WINDOW) begin
            window_edges[sel] = '0;
            min_capture[sel]  = PERIOD_ONES;
            max_capture[sel]  = '0;
         end else if (op.opcode == mcppm_pkg::OP_CLEAR_SUM) begin
            total_edges[sel] = '0;
         end
      end
      return r;
   endfunction

   task automatic compare_field(string name, logic [31:0] expected, logic [31:0] actual);
      if (actual !== expected) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch on beat %0d, %s: expected 0x%0h, got 0x%0h",
                     checked_readings, name, expected, actual);
      end
   endtask

   task automatic queue_op(mcppm_pkg::opcode_type op, pin_set_type pins,
                           channel_sel_type channel);
      meter_op_type item;
      item.opcode  = op;
      item.pins    = pins;
      item.channel = channel;
      op_backlog.push_back(item);
      queued_ops++;
   endtask

   task automatic queue_random_ops(int count);
      int pick;
      pin_set_type pins;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            for (int c = 0; c < CHANNEL_COUNT; c++) begin
               pins[c] = wave_level[c];
               wave_left[c]--;
               if (wave_left[c] <= 0) begin
                  wave_level[c] = !wave_level[c];
                  wave_left[c] = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 60)
                                                             : $urandom_range(1, 6);
               end
            end
            queue_op(mcppm_pkg::OP_TICK, pins, channel_sel_type'($urandom_range(0, 3)));
         end else if (pick < 78) begin
            queue_op(mcppm_pkg::OP_TICK, pin_set_type'($urandom_range(0, 7)),
                     channel_sel_type'($urandom_range(0, 3)));
         end else if (pick < 90) begin
            queue_op(mcppm_pkg::OP_READ, pin_set_type'($urandom_range(0, 7)),
                     channel_sel_type'($urandom_range(0, 3)));
         end else if (pick < 95) begin
            queue_op(mcppm_pkg::OP_CLEAR_WINDOW, pin_set_type'($urandom_range(0, 7)),
                     channel_sel_type'($urandom_range(0, 3)));
         end else begin
            queue_op(mcppm_pkg::OP_CLEAR_SUM, pin_set_type'($urandom_range(0, 7)),
                     channel_sel_type'($urandom_range(0, 3)));
         end
      end
   endtask

   // The sender holds off here until every predicted beat has come back.
   task automatic drain_readings();
      while (accepted_ops != queued_ops || predicted_readings.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_transfer(logic write, divider_type value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= DIVIDER_ADDR;
      pwdata  <= {{(mcppm_pkg::CSR_DATA_BITS-mcppm_pkg::DIVIDER_BITS){1'b0}}, value};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_divider(divider_type value);
      csr_transfer(1'b1, value);
      csr_transfer(1'b0, value);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
   end

   // Request driver: a new beat is offered once the previous one has been taken.
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid      <= 1'b0;
         req_bus.opcode     <= '0;
         req_bus.pin_levels <= '0;
         req_bus.channel    <= '0;
         send_hold <= 0;
      end else if (!req_bus.valid || req_taken) begin
         if (send_hold > 0) begin
            req_bus.valid <= 1'b0;
            send_hold <= send_hold - 1;
         end else if (op_backlog.size() == 0) begin
            req_bus.valid <= 1'b0;
         end else if (!no_idling && $urandom_range(0, 19) == 0) begin
            req_bus.valid <= 1'b0;
            send_hold <= $urandom_range(0, 16);
         end else begin
            next_op = op_backlog.pop_front();
            req_bus.valid      <= 1'b1;
            req_bus.opcode     <= next_op.opcode;
            req_bus.pin_levels <= next_op.pins;
            req_bus.channel    <= next_op.channel;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!no_idling && $urandom_range(0, 19) == 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= $urandom_range(0, 16);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Monitor: tracks divider writes and readbacks, predicts on every accepted
   // request beat and checks every response beat.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         prev_level = '0;
         counting = '0;
         divider = '0;
         divider_limit = mcppm_pkg::TICKS_PER_MS_RESET;
         for (int c = 0; c < CHANNEL_COUNT; c++) begin
            period_cnt[c]   = '0;
            last_capture[c] = '0;
            window_edges[c] = '0;
            total_edges[c]  = '0;
            min_capture[c]  = PERIOD_ONES;
            max_capture[c]  = '0;
         end
      end else begin
         req_taken <= req_bus.valid && req_bus.ready;
         if (psel === 1'b1 && penable === 1'b1 && pready === 1'b1 && paddr == DIVIDER_ADDR) begin
            if (pwrite)
               divider_limit = pwdata[mcppm_pkg::DIVIDER_BITS-1:0];
            else
               compare_field("ticks_per_millisecond readback",
                  {{(mcppm_pkg::CSR_DATA_BITS-mcppm_pkg::DIVIDER_BITS){1'b0}}, divider_limit},
                  prdata);
         end
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
            seen_op.opcode  = mcppm_pkg::opcode_type'(req_bus.opcode);
            seen_op.pins    = req_bus.pin_levels;
            seen_op.channel = req_bus.channel;
            predicted_readings.push_back(advance_meter(seen_op));
            accepted_ops++;
         end
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (predicted_readings.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: response beat %0d arrived with none predicted",
                           checked_readings);
            end else begin
               want = predicted_readings.pop_front();
               compare_field("millisecond_strobe", 32'(want.strobe),
                             32'(rsp_bus.millisecond_strobe));
               compare_field("capture_mask", 32'(want.mask), 32'(rsp_bus.capture_mask));
               compare_field("period_zero", 32'(want.period_zero), 32'(rsp_bus.period_zero));
               compare_field("period_one", 32'(want.period_one), 32'(rsp_bus.period_one));
               compare_field("period_two", 32'(want.period_two), 32'(rsp_bus.period_two));
               compare_field("stat_count", 32'(want.edges), 32'(rsp_bus.stat_count));
               compare_field("stat_sum", want.total, rsp_bus.stat_sum);
               compare_field("stat_min", 32'(want.shortest), 32'(rsp_bus.stat_min));
               compare_field("stat_max", 32'(want.longest), 32'(rsp_bus.stat_max));
               compare_field("stat_last", 32'(want.latest), 32'(rsp_bus.stat_last));
            end
            checked_readings++;
         end
      end
   end

   initial begin
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      no_idling = 1'b0;
      queued_ops = 0;
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
         wave_level[c]   = ($urandom_range(0, 1) == 1);
         wave_left[c]    = $urandom_range(1, 6);
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset statistics, first edge without capture, captures on
      // all channels, clears on a valid and an out-of-range channel, strobe.
      for (int c = 0; c <= 3; c++)
         queue_op(mcppm_pkg::OP_READ, 3'b111, channel_sel_type'(c));
      queue_op(mcppm_pkg::OP_TICK, 3'b111, 2'd3);
      queue_op(mcppm_pkg::OP_TICK, 3'b000, 2'd0);
      queue_op(mcppm_pkg::OP_TICK, 3'b111, 2'd1);
      queue_op(mcppm_pkg::OP_TICK, 3'b000, 2'd2);
      queue_op(mcppm_pkg::OP_TICK, 3'b101, 2'd0);
      queue_op(mcppm_pkg::OP_TICK, 3'b000, 2'd0);
      queue_op(mcppm_pkg::OP_TICK, 3'b010, 2'd0);
      queue_op(mcppm_pkg::OP_TICK, 3'b000, 2'd0);
      queue_op(mcppm_pkg::OP_READ, 3'b000, 2'd1);
      queue_op(mcppm_pkg::OP_CLEAR_WINDOW, 3'b010, 2'd1);
      queue_op(mcppm_pkg::OP_READ, 3'b101, 2'd1);
      queue_op(mcppm_pkg::OP_CLEAR_SUM, 3'b000, 2'd2);
      queue_op(mcppm_pkg::OP_READ, 3'b000, 2'd2);
      queue_op(mcppm_pkg::OP_CLEAR_WINDOW, 3'b000, 2'd3);
      queue_op(mcppm_pkg::OP_CLEAR_SUM, 3'b111, 2'd3);
      queue_op(mcppm_pkg::OP_READ, 3'b000, 2'd3);
      queue_op(mcppm_pkg::OP_TICK, 3'b111, 2'd0);
      queue_op(mcppm_pkg::OP_TICK, 3'b011, 2'd0);
      queue_op(mcppm_pkg::OP_TICK, 3'b000, 2'd0);
      drain_readings();

      set_divider(8'd1);
      queue_random_ops(100);
      drain_readings();

      set_divider(8'd255);
      queue_random_ops(150);
      drain_readings();

      // Lowering the limit below the running divider makes it wrap through 255.
      set_divider(8'd3);
      queue_random_ops(100);
      drain_readings();

      set_divider(8'd0);
      queue_random_ops(200);
      drain_readings();

      // The closing phase runs without any idling on either side.
      no_idling = 1'b1;
      set_divider(divider_type'($urandom_range(1, 255)));
      queue_random_ops(100);
      drain_readings();
      repeat (10) @(posedge clock);

      if (mismatches == 0 && predicted_readings.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
